// ===== src/bre_pkg.sv =====
// Shared constants, codes and the work descriptor type for the binary rectangular erosion block.
package bre_pkg;

    localparam int MaxWidth  = 1024;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int MaxKernel = 64;
    localparam int RingRows  = MaxKernel + 1;
    localparam int SlotW     = $clog2(RingRows);
    localparam int HeadCols  = MaxKernel / 2;
    localparam int BankDepth = MaxKernel;
    localparam int HalfW     = $clog2(HeadCols + 1);
    localparam int KernW     = 7;
    localparam int WidthW    = 11;
    localparam int HeightW   = 16;
    localparam int RowW      = HeightW + 1;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;
    localparam int PixW      = 8;
    localparam logic [PixW-1:0] FgLevel = 8'd255;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_ROWS  = 2'd2,
        CFG_KERNEL_COLS  = 2'd3
    } t_cfg_idx;

    // One unit of work: the history write of an item and the output it causes.
    typedef struct packed {
        logic             wr_en;
        logic [ColW-1:0]  wcol;
        logic [SlotW-1:0] wslot;
        logic             wbit;
        logic             out_en;
        logic             last;
        logic [SlotW-1:0] s0;
        logic [SlotW-1:0] slen;
        logic [ColW-1:0]  c0;
        logic [ColW-1:0]  c1;
    } t_op;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_opq_hs;

endpackage

// ===== src/bre_front.sv =====
// Front end: configuration registers, raster counters and work descriptor generation.
module bre_front import bre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_accept,
    input  logic [PixW-1:0]     i_pixel,
    output t_op                 o_op
);

    logic [WidthW-1:0]  r_img_w;
    logic [HeightW-1:0] r_img_h;
    logic [KernW-1:0]   r_krows, r_kcols;
    logic [ColW-1:0]    r_wc, n_wc, r_oj, n_oj;
    logic [RowW-1:0]    r_wr, n_wr;
    logic [SlotW-1:0]   r_wslot, n_wslot, r_oslot, n_oslot;
    logic [5:0]         r_lag, n_lag;
    logic [HeightW-1:0] r_oi, n_oi;

    logic [WidthW-1:0]  w, wm1, c1_raw;
    logic [HeightW-1:0] h, hm1, rtop, rbot;
    logic [KernW-1:0]   kr, kc, low_r, low_c;
    logic [HalfW-1:0]   half_r, half_c;
    logic [RowW-1:0]    rbot_raw;
    logic               base, out_en, wr_en, last;
    t_cfg_idx           cfg_idx;

    assign cfg_idx = t_cfg_idx'(i_cfg_idx);

    always_comb begin
        if (r_img_w == '0) begin
            w = WidthW'(1);
        end else if (r_img_w > WidthW'(MaxWidth)) begin
            w = WidthW'(MaxWidth);
        end else begin
            w = r_img_w;
        end
        h  = (r_img_h == '0) ? HeightW'(1) : r_img_h;
        kr = (r_krows == '0) ? KernW'(1) :
             ((r_krows > KernW'(MaxKernel)) ? KernW'(MaxKernel) : r_krows);
        kc = (r_kcols == '0) ? KernW'(1) :
             ((r_kcols > KernW'(MaxKernel)) ? KernW'(MaxKernel) : r_kcols);
        half_r = HalfW'(kr >> 1);
        half_c = HalfW'(kc >> 1);
        low_r  = kr - KernW'(1) - KernW'(half_r);
        low_c  = kc - KernW'(1) - KernW'(half_c);
        wm1    = w - WidthW'(1);
        hm1    = h - HeightW'(1);

        wr_en  = r_wr < RowW'(h);
        base   = r_wr >= RowW'(half_r);
        out_en = base && (r_lag >= 6'(half_c));

        // Window rows, clipped to the image, as a ring slot range.
        if (r_oi >= HeightW'(half_r)) begin
            rtop = r_oi - HeightW'(half_r);
            o_op.s0 = (r_oslot >= SlotW'(half_r)) ? r_oslot - SlotW'(half_r)
                      : r_oslot + SlotW'(RingRows) - SlotW'(half_r);
        end else begin
            rtop = '0;
            o_op.s0 = '0;
        end
        rbot_raw = RowW'(r_oi) + RowW'(low_r);
        rbot     = (rbot_raw > RowW'(hm1)) ? hm1 : rbot_raw[HeightW-1:0];
        o_op.slen = SlotW'(rbot - rtop + HeightW'(1));

        o_op.c0 = (r_oj >= ColW'(half_c)) ? r_oj - ColW'(half_c) : '0;
        c1_raw  = WidthW'(r_oj) + WidthW'(low_c);
        o_op.c1 = (c1_raw > wm1) ? wm1[ColW-1:0] : c1_raw[ColW-1:0];

        last = out_en && (r_oi == hm1) && (r_oj == wm1[ColW-1:0]);

        o_op.wr_en  = wr_en;
        o_op.wcol   = r_wc;
        o_op.wslot  = r_wslot;
        o_op.wbit   = (i_pixel == FgLevel);
        o_op.out_en = out_en;
        o_op.last   = last;

        n_wc = r_wc; n_wr = r_wr; n_wslot = r_wslot; n_lag = r_lag;
        n_oj = r_oj; n_oi = r_oi; n_oslot = r_oslot;
        if (last) begin
            n_wc = '0; n_wr = '0; n_wslot = '0; n_lag = '0;
            n_oj = '0; n_oi = '0; n_oslot = '0;
        end else begin
            if (WidthW'(r_wc) == wm1) begin
                n_wc    = '0;
                n_wr    = r_wr + RowW'(1);
                n_wslot = (r_wslot == SlotW'(RingRows - 1)) ? '0 : r_wslot + SlotW'(1);
            end else begin
                n_wc = r_wc + ColW'(1);
            end
            if (base && (r_lag != '1)) begin
                n_lag = r_lag + 6'd1;
            end
            if (out_en) begin
                if (WidthW'(r_oj) == wm1) begin
                    n_oj    = '0;
                    n_oi    = r_oi + HeightW'(1);
                    n_oslot = (r_oslot == SlotW'(RingRows - 1)) ? '0
                              : r_oslot + SlotW'(1);
                end else begin
                    n_oj = r_oj + ColW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WidthW'(640);
            r_img_h <= HeightW'(480);
            r_krows <= KernW'(45);
            r_kcols <= KernW'(45);
            r_wc <= '0; r_wr <= '0; r_wslot <= '0; r_lag <= '0;
            r_oj <= '0; r_oi <= '0; r_oslot <= '0;
        end else if (i_cfg_we) begin
            case (cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[WidthW-1:0];
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[HeightW-1:0];
                CFG_KERNEL_ROWS:  r_krows <= i_cfg_data[KernW-1:0];
                CFG_KERNEL_COLS:  r_kcols <= i_cfg_data[KernW-1:0];
                default:          r_img_w <= r_img_w;
            endcase
            r_wc <= '0; r_wr <= '0; r_wslot <= '0; r_lag <= '0;
            r_oj <= '0; r_oi <= '0; r_oslot <= '0;
        end else if (i_accept) begin
            r_wc <= n_wc; r_wr <= n_wr; r_wslot <= n_wslot; r_lag <= n_lag;
            r_oj <= n_oj; r_oi <= n_oi; r_oslot <= n_oslot;
        end
    end

endmodule

// ===== src/bre_opq.sv =====
// Four-entry queue of work descriptors between the front end and the back end.
module bre_opq import bre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_op,
    output logic    o_full,
    output t_op     o_op,
    input  t_opq_hs i_hs_pop,
    output t_opq_hs o_hs
);

    t_op        r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_pop;

    assign o_full      = (r_cnt == 3'd4);
    assign o_hs.valid  = (r_cnt != 3'd0);
    assign o_hs.pop    = do_pop;
    assign do_pop      = i_hs_pop.pop && o_hs.valid;
    assign o_op        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(do_pop);
        end
    end

endmodule

// ===== src/bre_back.sv =====
// Back end: column history memory, window column banks, window evaluation and result queue.
module bre_back import bre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_op     i_op,
    input  t_opq_hs i_hs,
    output t_opq_hs o_hs,
    input  logic    i_pop,
    output logic    o_empty,
    output logic    o_fg,
    output logic    o_last
);

    logic [RingRows-1:0] r_mem  [MaxWidth];
    logic [RingRows-1:0] r_head [HeadCols];
    logic [RingRows-1:0] r_bank [BankDepth];
    logic [ColW-1:0]     r_tag  [BankDepth];
    logic [RingRows-1:0] r_rdata, merged;

    logic                r_vb, r_vc, r_outc, r_lastc;
    t_op                 r_opb;
    logic [RingRows-1:0] smask, r_smask;
    logic [HeadCols-1:0] hmask, r_hmask;
    logic [BankDepth-1:0] mmask, r_mmask;

    logic [1:0] r_ofg  [4];
    logic [1:0] r_owp, r_orp;
    logic [2:0] r_ocnt, infl;
    logic       take, ld_en, fg, opush, opop;
    logic [ColW-1:0]  lo_col;
    logic [KernW-1:0] mlen;
    logic [SlotW-1:0] sd;
    logic [5:0]       md;

    assign infl  = 3'(r_vb & r_opb.out_en) + 3'(r_vc & r_outc);
    assign take  = i_hs.valid && ((r_ocnt + infl) < 3'd4);
    assign o_hs.pop   = take;
    assign o_hs.valid = r_vb;

    // Memory stage: bit write of the history and read of the entering column.
    always_ff @(posedge i_clk) begin
        if (take && i_op.wr_en) begin
            r_mem[i_op.wcol][i_op.wslot] <= i_op.wbit;
        end
        if (take) begin
            r_rdata <= r_mem[i_op.c1];
            r_opb   <= i_op;
        end
    end

    always_comb begin
        merged = r_rdata;
        if (r_opb.wr_en && (r_opb.wcol == r_opb.c1)) begin
            merged[r_opb.wslot] = r_opb.wbit;
        end
        ld_en = r_opb.out_en && (r_opb.c1 >= ColW'(HeadCols));

        for (int s = 0; s < RingRows; s++) begin
            sd = (SlotW'(s) >= r_opb.s0) ? SlotW'(s) - r_opb.s0
                 : SlotW'(s) + SlotW'(RingRows) - r_opb.s0;
            smask[s] = sd < r_opb.slen;
        end
        for (int c = 0; c < HeadCols; c++) begin
            hmask[c] = (ColW'(c) >= r_opb.c0) && (ColW'(c) <= r_opb.c1);
        end
        lo_col = (r_opb.c0 > ColW'(HeadCols)) ? r_opb.c0 : ColW'(HeadCols);
        mlen   = (r_opb.c1 >= lo_col) ? KernW'(r_opb.c1 - lo_col + ColW'(1)) : '0;
        for (int e = 0; e < BankDepth; e++) begin
            md       = 6'(e) - lo_col[5:0];
            mmask[e] = KernW'(md) < mlen;
        end
    end

    // Bank stage: keep mirrored columns current and load the entering one.
    always_ff @(posedge i_clk) begin
        if (r_vb) begin
            if (r_opb.wr_en && (r_opb.wcol < ColW'(HeadCols))) begin
                r_head[r_opb.wcol[HalfW-2:0]][r_opb.wslot] <= r_opb.wbit;
            end
            for (int e = 0; e < BankDepth; e++) begin
                if (r_opb.wr_en && (r_tag[e] == r_opb.wcol)) begin
                    r_bank[e][r_opb.wslot] <= r_opb.wbit;
                end
            end
            if (ld_en) begin
                r_bank[r_opb.c1[5:0]] <= merged;
                r_tag[r_opb.c1[5:0]]  <= r_opb.c1;
            end
        end
        r_smask <= smask;
        r_hmask <= hmask;
        r_mmask <= mmask;
        r_outc  <= r_opb.out_en;
        r_lastc <= r_opb.last;
    end

    // Evaluation stage: every selected slot of every selected column must be set.
    always_comb begin
        fg = 1'b1;
        for (int c = 0; c < HeadCols; c++) begin
            if (r_hmask[c] && ((r_head[c] | ~r_smask) != '1)) begin
                fg = 1'b0;
            end
        end
        for (int e = 0; e < BankDepth; e++) begin
            if (r_mmask[e] && ((r_bank[e] | ~r_smask) != '1)) begin
                fg = 1'b0;
            end
        end
    end

    assign opush   = r_vc && r_outc;
    assign opop    = i_pop && !o_empty;
    assign o_empty = (r_ocnt == 3'd0);
    assign o_fg    = r_ofg[r_orp][1];
    assign o_last  = r_ofg[r_orp][0];

    always_ff @(posedge i_clk) begin
        if (opush) begin
            r_ofg[r_owp] <= {fg, r_lastc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb   <= 1'b0;
            r_vc   <= 1'b0;
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            r_vb <= take;
            r_vc <= r_vb;
            if (opush) begin
                r_owp <= r_owp + 2'd1;
            end
            if (opop) begin
                r_orp <= r_orp + 2'd1;
            end
            r_ocnt <= r_ocnt + 3'(opush) - 3'(opop);
        end
    end

endmodule

// ===== src/binary_rect_erosion.sv =====
// Top level of the streaming binary erosion block with a rectangular structuring element.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  input    | push / full          | i_pixel_in (8 bits, gray level)
//  result   | pop / empty          | o_pixel_out (0 or 255), o_last_in_frame
//  config   | i_cfg_we             | i_cfg_idx (register index), i_cfg_data
//
// The block takes one pixel per clock cycle while full is low. A result passes
// from its transaction through the descriptor queue, the history memory read
// and the column bank update, then window evaluation and the result queue.
// Reset (i_rst_n low at a clock edge) restores the default geometry, restarts the
// frame and empties both queues; the history memory itself is not cleared.
// When results are not popped, the four-entry result queue fills, the back end
// stops draining the four-entry descriptor queue, and full then rises.
//
// The front end turns each input transaction into a descriptor: where the pixel's
// foreground bit goes in the per-column row ring, whether an output is due, and
// the clipped window bounds of that output. The back end applies the history
// write and evaluates the window against mirrored column words, so each result
// sees exactly the history as it stands after its own input pixel.
module binary_rect_erosion import bre_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [PixW-1:0]     i_pixel_in,
    output logic                empty,
    input  logic                pop,
    output logic [PixW-1:0]     o_pixel_out,
    output logic                o_last_in_frame
);

    t_op     front_op, queue_op;
    t_opq_hs queue_hs, back_hs;
    logic    accept, fg;

    assign accept = push && !full;

    bre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pixel_in),
        .o_op       (front_op)
    );

    bre_opq u_opq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_op     (front_op),
        .o_full   (full),
        .o_op     (queue_op),
        .i_hs_pop (back_hs),
        .o_hs     (queue_hs)
    );

    bre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (queue_op),
        .i_hs    (queue_hs),
        .o_hs    (back_hs),
        .i_pop   (pop),
        .o_empty (empty),
        .o_fg    (fg),
        .o_last  (o_last_in_frame)
    );

    // Eroded pixels are strictly binary.
    assign o_pixel_out = fg ? FgLevel : '0;

    // A result shown on the ports is always black or white.
    a_binary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_pixel_out == FgLevel || o_pixel_out == '0))
        else $error("result pixel is neither 0 nor 255");

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset leaves room for input.
    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the streaming binary rectangular erosion block.
`timescale 1ns / 100ps

module tb;
    import bre_pkg::*;

    // One eroded output pixel as the block should present it.
    typedef struct {
        logic [PixW-1:0] pix;
        logic            last;
    } t_eroded;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = CFG_IMAGE_WIDTH;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [PixW-1:0]     i_pixel_in = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [PixW-1:0]     o_pixel_out;
    logic                o_last_in_frame;

    binary_rect_erosion u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_pixel_in     (i_pixel_in),
        .empty          (empty),
        .pop            (pop),
        .o_pixel_out    (o_pixel_out),
        .o_last_in_frame(o_last_in_frame)
    );

    always #2 i_clk = ~i_clk;

    // Pixels waiting to be offered and eroded pixels waiting to be popped.
    logic [PixW-1:0] pixel_backlog[$];
    t_eroded         eroded_due[$];

    // Gray levels at and around the extremes and the midpoint of the pixel range, and two more.
    logic [PixW-1:0] corner_px [9] = '{8'd0, 8'd255, 8'd254, 8'd1, 8'd128, 8'd127,
                                       8'd255, 8'd85, 8'd170};

    int unsigned n_errors = 0;
    int unsigned n_pixels_taken = 0;
    int unsigned n_eroded_seen = 0;
    int unsigned n_frames_seen = 0;
    int unsigned n_geometries = 0;

    // Idle percentages for the sender and the receiver; the receiver can also
    // be held off completely for a long stretch.
    int unsigned push_idle_pct = 25;
    int unsigned pop_idle_pct = 82;
    logic        pop_hold = 1'b0;

    // Mirror of the geometry registers as written, before clamping.
    logic [WidthW-1:0]  geo_width;
    logic [HeightW-1:0] geo_height;
    logic [KernW-1:0]   geo_krows;
    logic [KernW-1:0]   geo_kcols;
    int unsigned        frame_pos;

    // Foreground bit of each column for the last RingRows rows, one slot per
    // row modulo RingRows.
    bit fg_ring [0:MaxWidth-1][0:RingRows-1];

    function automatic int unsigned clamp_geo(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Stores the foreground bit of the pixel just taken and, once the frame has
    // advanced far enough, queues the eroded pixel that falls due with it.
    function automatic void erode_pixel(logic [PixW-1:0] px);
        int unsigned w, h, kr, kc, area, lag, o;
        int r0, r1, c0, c1, oi, oj;
        bit all_fg;
        t_eroded res;
        w = clamp_geo(geo_width, MaxWidth);
        h = clamp_geo(geo_height, 65535);
        kr = clamp_geo(geo_krows, MaxKernel);
        kc = clamp_geo(geo_kcols, MaxKernel);
        area = w * h;
        lag = (kr / 2) * w + kc / 2;
        // Filler pixels past the end of the image are not stored.
        if (frame_pos < area)
            fg_ring[frame_pos % w][(frame_pos / w) % RingRows] = (px == FgLevel);
        if (frame_pos < lag) begin
            frame_pos++;
            return;
        end
        o = frame_pos - lag;
        if (o >= area) begin
            frame_pos = 0;
            return;
        end
        oi = o / w;
        oj = o % w;
        r0 = oi - int'(kr / 2);
        c0 = oj - int'(kc / 2);
        r1 = r0 + int'(kr) - 1;
        c1 = c0 + int'(kc) - 1;
        if (r0 < 0) r0 = 0;
        if (c0 < 0) c0 = 0;
        if (r1 > int'(h) - 1) r1 = h - 1;
        if (c1 > int'(w) - 1) c1 = w - 1;
        all_fg = 1'b1;
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                if (!fg_ring[c][r % RingRows]) all_fg = 1'b0;
        res.pix = all_fg ? FgLevel : '0;
        res.last = (o == area - 1);
        eroded_due.push_back(res);
        frame_pos = res.last ? 0 : frame_pos + 1;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    // Driver: offers backlog pixels, holding an offer until full drops.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                erode_pixel(i_pixel_in);
                n_pixels_taken++;
            end
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= push_idle_pct) begin
                push <= 1'b1;
                i_pixel_in <= pixel_backlog.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: pops at random and checks every result transaction.
    always @(posedge i_clk) begin
        t_eroded want;
        if (i_rst_n && pop && !empty) begin
            n_eroded_seen++;
            if (o_last_in_frame) n_frames_seen++;
            if (eroded_due.size() == 0) begin
                $display("[%0t] unexpected result transaction", $time);
                n_errors++;
            end else begin
                want = eroded_due.pop_front();
                if (o_pixel_out !== want.pix)
                    report_mismatch("pixel_out", o_pixel_out, want.pix);
                if (o_last_in_frame !== want.last)
                    report_mismatch("last_in_frame", o_last_in_frame, want.last);
            end
        end
        pop <= i_rst_n && !pop_hold && ($urandom_range(99) >= pop_idle_pct);
    end

    task automatic write_geo(t_cfg_idx idx, logic [CfgDataW-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_IMAGE_WIDTH:  geo_width = data[WidthW-1:0];
            CFG_IMAGE_HEIGHT: geo_height = data[HeightW-1:0];
            CFG_KERNEL_ROWS:  geo_krows = data[KernW-1:0];
            CFG_KERNEL_COLS:  geo_kcols = data[KernW-1:0];
            default: ;
        endcase
        frame_pos = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned kr,
                                int unsigned kc);
        write_geo(CFG_IMAGE_WIDTH, CfgDataW'(w));
        write_geo(CFG_IMAGE_HEIGHT, CfgDataW'(h));
        write_geo(CFG_KERNEL_ROWS, CfgDataW'(kr));
        write_geo(CFG_KERNEL_COLS, CfgDataW'(kc));
        n_geometries++;
    endtask

    // Waits until every pixel went in and every result came out, then lets the
    // pipeline settle, since trailing pixels may cause no result at all.
    task automatic drain();
        while (pixel_backlog.size() != 0 || push || eroded_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [PixW-1:0] rand_pixel();
        // Mostly foreground so that eroded foreground survives in small windows.
        if ($urandom_range(99) < 85) return FgLevel;
        return PixW'($urandom_range(255));
    endfunction

    task automatic queue_frames(int unsigned w, int unsigned h, int unsigned kr,
                                int unsigned kc, int unsigned n_frames,
                                int unsigned extra);
        int unsigned per_frame;
        per_frame = w * h + (kr / 2) * w + kc / 2;
        repeat (n_frames * per_frame + extra) pixel_backlog.push_back(rand_pixel());
    endtask

    initial begin
        int unsigned w, h, kr, kc;
        geo_width = 640;
        geo_height = 480;
        geo_krows = 45;
        geo_kcols = 45;
        frame_pos = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero registers count as one: a single pixel image, so every pixel is
        // its own last result. Extremes of the pixel range go through here.
        set_geometry(0, 0, 0, 0);
        foreach (corner_px[i])
            pixel_backlog.push_back(corner_px[i]);
        drain();

        // A small frame with a 3x3 window, two frames back to back.
        set_geometry(4, 3, 3, 3);
        queue_frames(4, 3, 3, 3, 2, 0);
        drain();

        // Oversized width saturates, the tallest height never completes a frame.
        set_geometry(16'h07FF, 16'hFFFF, 1, 2);
        queue_frames(1, 1, 1, 1, 0, 60);
        drain();

        // Oversized kernels saturate to the largest window, which covers the
        // whole tiny image. The receiver is held off meanwhile to back up the
        // block until it refuses input.
        set_geometry(5, 4, 16'h007F, 16'h007F);
        fork
            begin
                pop_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                pop_hold <= 1'b0;
            end
        join_none
        queue_frames(5, 4, 64, 64, 2, 0);
        drain();

        // Random geometries, whole frames plus a few stray pixels that leave a
        // frame unfinished before the next register write restarts it.
        while (n_pixels_taken < 1400) begin
            if (n_pixels_taken >= 900) begin
                push_idle_pct = 0;
                pop_idle_pct = 0;
            end else if (n_pixels_taken >= 450) begin
                push_idle_pct = 82;
                pop_idle_pct = 25;
            end
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            kr = $urandom_range(1, 6);
            kc = $urandom_range(1, 6);
            set_geometry(w, h, kr, kc);
            queue_frames(w, h, kr, kc, $urandom_range(1, 3), $urandom_range(0, 3));
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d geometries: %0d pixels in, %0d eroded pixels out, %0d frames.",
                 n_geometries, n_pixels_taken, n_eroded_seen, n_frames_seen);
        if (n_errors == 0 && eroded_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", n_errors,
                     eroded_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", eroded_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
